### design/vorbis_comment_header_parser_defines.svh
// Assertion macros for the comment header parser. Each macro expects a clock
// named clk and an active-low reset named rst_n in the scope where it is used.
`ifndef VORBIS_COMMENT_HEADER_PARSER_DEFINES_SVH
`define VORBIS_COMMENT_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define VCHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vchp assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define VCHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vchp assertion failed");
`else
`define VCHP_ASSERT_NOW(label, ante, cons)
`define VCHP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/vchp_pkg.sv
package vchp_pkg;

    // Every length and count field is four bytes, little-endian.
    localparam logic [31:0] LEN_BYTES = 32'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_VLEN  = 3'd1,
        PH_VSKIP = 3'd2,
        PH_COUNT = 3'd3,
        PH_CLEN  = 3'd4,
        PH_CBODY = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef struct packed {
        logic        first_byte;
        logic [7:0]  data_byte;
        logic [31:0] packet_bytes;
    } item_t;

    typedef struct packed {
        logic [30:0] comment_number;
        logic [7:0]  comment_byte;
        logic        end_of_comment;
        logic        empty_comment;
    } result_t;

endpackage

### design/vchp_in_reg.sv
module vchp_in_reg
    import vchp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        advance,
    output logic        in_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The register frees up in the same cycle its beat moves on.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.first_byte   <= s_tuser;
            item_reg.data_byte    <= s_tdata[7:0];
            item_reg.packet_bytes <= s_tdata[39:8];
        end
    end

    assign in_valid = valid_reg;
    assign item     = item_reg;

endmodule

### design/vchp_parse.sv
module vchp_parse
    import vchp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    phase_t      phase_reg, phase_next, ph_e;
    logic [31:0] pos_reg, pos_next, pos_e;
    logic [31:0] acc_reg, acc_next, acc_e;
    logic [31:0] left_reg, left_next, left_e;
    logic [30:0] cl_reg, cl_next, cl_e;
    logic [30:0] cc_reg, cc_next, cc_e;

    logic [1:0]  idx;
    logic [31:0] acc_new;
    logic [31:0] left_dec;
    logic        field_done;
    logic [31:0] pos_inc;
    logic        past_end;
    logic        vlen_over;
    logic        clen_over;
    logic [30:0] cl_dec;
    logic        active;

    // A first byte restarts the parse before the byte itself is looked at.
    always_comb
    begin
        ph_e   = item.first_byte ? PH_VLEN : phase_reg;
        pos_e  = item.first_byte ? 32'd0 : pos_reg;
        acc_e  = item.first_byte ? 32'd0 : acc_reg;
        left_e = item.first_byte ? LEN_BYTES : left_reg;
        cl_e   = item.first_byte ? 31'd0 : cl_reg;
        cc_e   = item.first_byte ? 31'd0 : cc_reg;
    end

    assign idx        = 2'd0 - left_e[1:0];
    assign acc_new    = acc_e | ({24'd0, item.data_byte} << {idx, 3'b000});
    assign left_dec   = left_e - 32'd1;
    assign field_done = (left_dec == 32'd0);
    assign pos_inc    = pos_e + 32'd1;
    assign past_end   = (pos_e >= item.packet_bytes);
    assign vlen_over  = ({2'b00, pos_inc} + {2'b00, acc_new} + {2'b00, LEN_BYTES})
                        > {2'b00, item.packet_bytes};
    assign clen_over  = ({1'b0, pos_inc} + {1'b0, acc_new}) > {1'b0, item.packet_bytes};
    assign cl_dec     = cl_e - 31'd1;
    assign active     = !(ph_e inside {PH_IDLE, PH_DONE}) && !past_end;

    always_comb
    begin
        phase_next = ph_e;
        pos_next   = pos_e;
        acc_next   = acc_e;
        left_next  = left_e;
        cl_next    = cl_e;
        cc_next    = cc_e;
        if (!(ph_e inside {PH_IDLE, PH_DONE}))
        begin
            if (past_end)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                pos_next = pos_inc;
                case (ph_e)
                    PH_VLEN:
                    begin
                        acc_next  = acc_new;
                        left_next = left_dec;
                        if (field_done)
                        begin
                            if (acc_new[31] || vlen_over)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (acc_new == 32'd0)
                            begin
                                phase_next = PH_COUNT;
                                acc_next   = 32'd0;
                                left_next  = LEN_BYTES;
                            end
                            else
                            begin
                                phase_next = PH_VSKIP;
                                left_next  = acc_new;
                            end
                        end
                    end
                    PH_VSKIP:
                    begin
                        left_next = left_dec;
                        if (field_done)
                        begin
                            phase_next = PH_COUNT;
                            acc_next   = 32'd0;
                            left_next  = LEN_BYTES;
                        end
                    end
                    PH_COUNT:
                    begin
                        acc_next  = acc_new;
                        left_next = left_dec;
                        if (field_done)
                        begin
                            if (acc_new[31] || acc_new == 32'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                cl_next    = acc_new[30:0];
                                cc_next    = 31'd0;
                                phase_next = PH_CLEN;
                                acc_next   = 32'd0;
                                left_next  = LEN_BYTES;
                            end
                        end
                    end
                    PH_CLEN:
                    begin
                        acc_next  = acc_new;
                        left_next = left_dec;
                        if (field_done)
                        begin
                            if (acc_new[31] || clen_over)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (acc_new == 32'd0)
                            begin
                                cc_next = cc_e + 31'd1;
                                cl_next = cl_dec;
                                if (cl_dec == 31'd0)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_CLEN;
                                    acc_next   = 32'd0;
                                    left_next  = LEN_BYTES;
                                end
                            end
                            else
                            begin
                                phase_next = PH_CBODY;
                                left_next  = acc_new;
                            end
                        end
                    end
                    PH_CBODY:
                    begin
                        left_next = left_dec;
                        if (field_done)
                        begin
                            cc_next = cc_e + 31'd1;
                            cl_next = cl_dec;
                            if (cl_dec == 31'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_CLEN;
                                acc_next   = 32'd0;
                                left_next  = LEN_BYTES;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid          = 1'b0;
        res.comment_number = cc_e;
        res.comment_byte   = item.data_byte;
        res.end_of_comment = (left_e == 32'd1);
        res.empty_comment  = 1'b0;
        if (active)
        begin
            case (ph_e)
                PH_CLEN:
                begin
                    if (field_done && !acc_new[31] && !clen_over && acc_new == 32'd0)
                    begin
                        res_valid          = 1'b1;
                        res.comment_byte   = 8'd0;
                        res.end_of_comment = 1'b1;
                        res.empty_comment  = 1'b1;
                    end
                end
                PH_CBODY:
                begin
                    res_valid = 1'b1;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 32'd0;
            acc_reg   <= 32'd0;
            left_reg  <= 32'd0;
            cl_reg    <= 31'd0;
            cc_reg    <= 31'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            cl_reg    <= cl_next;
            cc_reg    <= cc_next;
        end
    end

endmodule

### design/vchp_out_reg.sv
module vchp_out_reg
    import vchp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, res_reg.comment_byte, res_reg.comment_number};
    assign m_tlast  = res_reg.end_of_comment;
    assign m_tuser  = res_reg.empty_comment;

endmodule

### design/vorbis_comment_header_parser.sv
// Comment header parser: takes a comment header packet one byte per beat on
// the slave stream and returns the bytes of each comment on the master stream.
// Slave beat: tuser marks the first byte of a packet and restarts the parse;
// tdata carries the byte and the packet's total size, repeated on every byte.
// Master beat: one comment byte with its zero-based comment index; tlast marks
// the final byte of a comment, and tuser marks an empty comment, which comes
// as a single beat with a zero byte and tlast set. Bytes of the vendor string,
// the length and count fields, and everything after the parse stops give no
// beat. A byte is parsed combinationally between the input register and the
// output register, so one byte per cycle is sustained while the receiver
// keeps tready high; its result is registered in the output register before
// it appears on the master side. Reset returns the parser to idle, waiting
// for a first byte, and empties both registers. When the receiver stalls,
// the output register holds its beat, the input register takes one more
// byte if it is empty, and then tready drops until the output beat is taken.
`include "vorbis_comment_header_parser_defines.svh"

module vorbis_comment_header_parser
    import vchp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], packet_bytes [39:8]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // comment_number [30:0], comment_byte [38:31], zero [39]
    output logic        m_tlast,   // end_of_comment
    output logic        m_tuser    // empty_comment
);

    logic    in_valid;
    item_t   item;
    logic    can_load;
    logic    advance;
    logic    res_valid;
    result_t res;
    logic    out_load;

    // A byte leaves the input register only when the output register can
    // take whatever result it gives, so the parse state and the output
    // always move together.
    assign advance  = in_valid && can_load;
    assign out_load = advance && res_valid;

    vchp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .in_valid (in_valid),
        .item     (item)
    );

    vchp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    vchp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An empty comment is always a last beat and carries a zero byte.
    `VCHP_ASSERT_NOW(a_empty_is_last, m_tvalid && m_tuser, m_tlast && m_tdata[38:31] == 8'd0)
    // With both registers full and the receiver stalled, no byte is taken.
    `VCHP_ASSERT_NOW(a_full_backpressure, in_valid && m_tvalid && !m_tready, !s_tready)
    // A taken output beat with nothing new behind it leaves the output empty.
    `VCHP_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !out_load, !m_tvalid)

endmodule
